FILE: hdl/fprc_pkg.sv
`timescale 1ns / 1ps

package fprc_pkg;

  // Field widths of one input word and one result word.
  localparam int unsigned PARENT_W = 29;
  localparam int unsigned MINT_W   = 10;
  localparam int unsigned MFRAC_W  = 24;
  localparam int unsigned PDIV_W   = 10;
  localparam int unsigned ODEXP_W  = 3;
  localparam int unsigned RATE_W   = 39;

  // Default width of the fraction that takes part in the multiplier.
  localparam int unsigned FRAC_BITS_DEF = 24;

  // Width of the shifted dividend: the product is below 2^(39+F), the rounding
  // term adds at most one bit, and the shift removes at least F bits.
  localparam int unsigned QUOT_W  = PARENT_W + MINT_W + 1;
  // Width of the summed output divider exponent (up to 14).
  localparam int unsigned SHIFT_W = ODEXP_W + 1;

  typedef struct packed {
    logic [PARENT_W-1:0] ref_rate;
    logic [MINT_W-1:0]   mult_int;
    logic [MFRAC_W-1:0]  mult_frac;
    logic [PDIV_W-1:0]   pre_div;
    logic [ODEXP_W-1:0]  out_div1_exp;
    logic [ODEXP_W-1:0]  out_div2_exp;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0] out_rate;
    logic              zero_div;
  } out_t;

  // Word handed from one divider cell to the next. The dividend and the
  // quotient share one register: each cell shifts one dividend bit out at
  // the top and one quotient bit in at the bottom.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [PDIV_W-1:0] div;
    logic [PDIV_W-1:0] rem;
    logic [QUOT_W-1:0] dq;
  } div_t;

endpackage

FILE: hdl/fprc_prep.sv
`timescale 1ns / 1ps

module fprc_prep #(
  parameter int unsigned FRAC_BITS = fprc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fprc_pkg::in_t  word_i,
  output fprc_pkg::div_t cell_o
);
  import fprc_pkg::*;

  localparam int unsigned PH_W  = PARENT_W + MINT_W;
  localparam int unsigned PL_W  = PARENT_W + FRAC_BITS;
  localparam int unsigned SUM_W = QUOT_W + FRAC_BITS;

  // Stage one: the two partial products of the multiplier.
  logic               v1_q, v2_q, v3_q;
  logic               zero1_q, zero2_q, zero3_q;
  logic [PDIV_W-1:0]  n1_q, n2_q, n3_q;
  logic [SHIFT_W-1:0] s1_q, s2_q;
  logic [PH_W-1:0]    ph1_q, ph1_d;
  logic [PL_W-1:0]    pl1_q, pl1_d;
  logic [SUM_W-1:0]   sum2_q, sum2_d, shifted;
  logic [QUOT_W-1:0]  q3_q;

  assign ph1_d = PH_W'(word_i.ref_rate) * PH_W'(word_i.mult_int);
  assign pl1_d = PL_W'(word_i.ref_rate) * PL_W'(word_i.mult_frac[FRAC_BITS-1:0]);

  // Stage two: full product plus half of the denominator.
  assign sum2_d = (SUM_W'(ph1_q) << FRAC_BITS) + SUM_W'(pl1_q)
                + ((SUM_W'(n1_q) << (FRAC_BITS - 1)) << s1_q);

  // Stage three: the power-of-two part of the denominator is a shift.
  assign shifted = (sum2_q >> FRAC_BITS) >> s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero1_q <= (word_i.pre_div == '0);
      n1_q    <= word_i.pre_div;
      s1_q    <= SHIFT_W'(word_i.out_div1_exp) + SHIFT_W'(word_i.out_div2_exp);
      ph1_q   <= ph1_d;
      pl1_q   <= pl1_d;
      zero2_q <= zero1_q;
      n2_q    <= n1_q;
      s2_q    <= s1_q;
      sum2_q  <= sum2_d;
      zero3_q <= zero2_q;
      n3_q    <= n2_q;
      q3_q    <= shifted[QUOT_W-1:0];
    end
  end

  always_comb begin
    cell_o.valid = v3_q;
    cell_o.zero  = zero3_q;
    cell_o.div   = n3_q;
    cell_o.rem   = '0;
    cell_o.dq    = q3_q;
  end

endmodule

FILE: hdl/fprc_div_cell.sv
`timescale 1ns / 1ps

module fprc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  fprc_pkg::div_t cell_i,
  output fprc_pkg::div_t cell_o
);
  import fprc_pkg::*;

  logic [PDIV_W:0]   trial, diff;
  logic              ge;
  div_t              nxt;
  logic              valid_q;
  logic              zero_q;
  logic [PDIV_W-1:0] div_q, rem_q;
  logic [QUOT_W-1:0] dq_q;

  // One restoring step: bring down the next dividend bit and subtract the
  // divisor where it fits.
  always_comb begin
    trial      = {cell_i.rem, cell_i.dq[QUOT_W-1]};
    diff       = trial - {1'b0, cell_i.div};
    ge         = (trial >= {1'b0, cell_i.div});
    nxt        = cell_i;
    nxt.rem    = ge ? diff[PDIV_W-1:0] : trial[PDIV_W-1:0];
    nxt.dq     = {cell_i.dq[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= nxt.zero;
      div_q  <= nxt.div;
      rem_q  <= nxt.rem;
      dq_q   <= nxt.dq;
    end
  end

  always_comb begin
    cell_o.valid = valid_q;
    cell_o.zero  = zero_q;
    cell_o.div   = div_q;
    cell_o.rem   = rem_q;
    cell_o.dq    = dq_q;
  end

endmodule

FILE: hdl/fprc_out_buf.sv
`timescale 1ns / 1ps

module fprc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fprc_pkg::out_t word_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fprc_pkg::out_t out_word_o
);
  import fprc_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  out_t       buf0_q, buf1_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = buf0_q;
  // Room depends on registered state only, so the pipeline enable never
  // waits on the downstream ready.
  assign room_o      = (cnt_q != 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i && cnt_q == 2'd1) begin
        buf0_q <= word_i;
      end else begin
        buf0_q <= buf1_q;
      end
      if (push_i && cnt_q == 2'd2) begin
        buf1_q <= word_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        buf0_q <= word_i;
      end else begin
        buf1_q <= word_i;
      end
    end
  end

endmodule

FILE: hdl/frac_pll_rate_calc.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid_i / in_ready_o   | in_word_i  (fprc_pkg::in_t)
// out     | output    | out_valid_o / out_ready_i | out_word_o (fprc_pkg::out_t)
//
// A word is taken every cycle while the output buffer has room; a result passes
// through three preparation stages, one divider cell per quotient bit (40),
// and the output buffer.
// Reset clears only the valid bits of the stages and the buffer count.
// The whole pipeline moves together while the two-entry output buffer has
// room; a stalled output only holds the input back once that buffer is full.

module frac_pll_rate_calc #(
  parameter int unsigned FRAC_BITS = fprc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fprc_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fprc_pkg::out_t out_word_o
);
  import fprc_pkg::*;

  // The rate is round(parent * (m * 2^F + frac) / (n * 2^F * 2^(od1 + od2))).
  // Since the denominator is n times a power of two, the rounding term is
  // added to the full product, the power of two is removed by a shift, and
  // only a division by the 10-bit pre-divider remains. The floor of a floor
  // equals the floor of the whole quotient, so the result is exact.
  logic en;
  div_t chain [QUOT_W+1];
  div_t tail;
  out_t res;

  assign in_ready_o = en;

  fprc_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .word_i (in_word_i),
    .cell_o (chain[0])
  );

  // Restoring divider: each cell decides one quotient bit, MSB first, and
  // passes its remainder to the next cell.
  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    fprc_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .cell_i(chain[i]),
      .cell_o(chain[i+1])
    );
  end

  assign tail = chain[QUOT_W];

  // A zero pre-divider gives a meaningless quotient, which is masked here.
  always_comb begin
    res.zero_div = tail.zero;
    res.out_rate = tail.zero ? '0 : tail.dq[RATE_W-1:0];
  end

  fprc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (en && tail.valid),
    .word_i     (res),
    .room_o     (en),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // Input is only held back while results are waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while no result is waiting");

  // The divider's final remainder is always smaller than the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.valid && !tail.zero) |-> (tail.rem < tail.div))
    else $error("divider remainder not below divisor");

  // A flagged zero pre-divider always leaves with a zero rate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.zero_div) |-> (out_word_o.out_rate == '0))
    else $error("nonzero rate with zero pre-divider");

  // With a full buffer and no pop, the pipeline must stay frozen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && !out_ready_i) |=> !en)
    else $error("buffer freed without a pop");

endmodule
